[rtl/lps_pkg.sv]
`timescale 1ns / 1ps

package lps_pkg;

    // Stream payload widths
    localparam int IN_W   = 72;
    localparam int OUT_W  = 32;
    localparam int USER_W = 2;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_RUN   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } lps_req_t;

    // Pattern codes
    typedef enum logic [2:0] {
        PAT_NONE      = 3'd0,
        PAT_SOLID     = 3'd1,
        PAT_BREATHE   = 3'd2,
        PAT_HEARTBEAT = 3'd3,
        PAT_BLINK     = 3'd4,
        PAT_SOS       = 3'd5,
        PAT_BLACK6    = 3'd6,
        PAT_BLACK7    = 3'd7
    } lps_pat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } lps_state_t;

    localparam logic [31:0] SOS_MASK = 32'h0153_BB95;

    // Scale thresholds (scale is carried as 9 bits plus a saturation flag,
    // the flag standing for scale >= 512)
    localparam logic [8:0] TH_FADE  = 9'd255;
    localparam logic [8:0] TH_BEAT  = 9'd32;
    localparam logic [8:0] TH_BLINK = 9'd64;

    // Last step of each stepping pattern before wrapping to zero
    localparam logic [5:0] HB_LAST    = 6'd6;
    localparam logic [5:0] BLINK_LAST = 6'd1;
    localparam logic [5:0] SOS_LAST   = 6'd31;

    // Breathe steps
    localparam logic [4:0] BR_FADE_IN  = 5'd0;
    localparam logic [4:0] BR_HOLD     = 5'd1;
    localparam logic [4:0] BR_FADE_OUT = 5'd2;
    localparam logic [4:0] BR_DARK     = 5'd3;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
        logic [2:0]  pattern_code;
        logic [7:0]  led_select;
        logic [31:0] now;
    } lps_in_t;

    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [5:0] led_number;
    } lps_out_t;

    // One table entry per LED
    typedef struct packed {
        logic [2:0]  pattern;
        logic [4:0]  step;
        logic [31:0] start;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } lps_entry_t;

    localparam int ENTRY_W = $bits(lps_entry_t);

    // Divider result: quotient valid when sat is low
    typedef struct packed {
        logic       sat;
        logic [8:0] quo;
    } lps_scale_t;

endpackage

[rtl/lps_ram.sv]
`timescale 1ns / 1ps

module lps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/lps_div.sv]
`timescale 1ns / 1ps

// Phase scale divider: quotient of num / den, one bit a cycle, reporting
// saturation at once when the quotient reaches 512.
module lps_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         num,
    input  logic [15:0]         den,
    output logic                done,
    output lps_pkg::lps_scale_t res
);

    import lps_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [8:0]  bits_reg, bits_next;
    lps_scale_t  res_reg, res_next;

    logic [16:0] cur;
    logic        sat_now;

    assign sat_now = {1'b0, num[31:9]} >= {8'd0, den};
    assign cur     = {rem_reg, bits_reg[8]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        res_next  = res_reg;
        if (start)
        begin
            den_next     = den;
            res_next.quo = '0;
            res_next.sat = sat_now;
            rem_next     = num[24:9];
            bits_next    = num[8:0];
            cnt_next     = 4'd9;
            busy_next    = !sat_now;
            done_next    = sat_now;
        end
        else if (busy_reg)
        begin
            // restoring step
            if (cur >= {1'b0, den_reg})
            begin
                rem_next     = 16'(cur - {1'b0, den_reg});
                res_next.quo = {res_reg.quo[7:0], 1'b1};
            end
            else
            begin
                rem_next     = cur[15:0];
                res_next.quo = {res_reg.quo[7:0], 1'b0};
            end
            bits_next = {bits_reg[7:0], 1'b0};
            cnt_next  = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg || done_reg))
        else $error("divider start lost");

endmodule

[rtl/led_pattern_sequencer_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: request fields, tuser: kind
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: LED color, tuser: write flag,
//                                                      tlast: final LED of a run
// cfg       in         cfg_valid / cfg_ready           cfg_data: period in ticks
//
// A set or clear reads the entry, merges the request and writes it back through the table RAM.
// For each LED a run does one table read, then the bit-serial phase divider (9 quotient bits,
// skipped when the scale is 512 or more), then update and write back.
// Reset clears every table entry at once through per-LED valid bits; the period
// returns to 1000 ticks. A stalled result output holds the walk in place; a new
// request is taken as soon as the last result of a run sits in the output register.
module led_pattern_sequencer_unit #(
    parameter int LED_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // now[31:0], led_select[39:32], pattern_code[42:40], red_in[50:43],
    // green_in[58:51], blue_in[66:59], zero fill above
    input  logic [lps_pkg::IN_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [lps_pkg::USER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // led_number[5:0], red_out[13:6], green_out[21:14], blue_out[29:22], zero fill above
    output logic [lps_pkg::OUT_W-1:0]   m_axis_tdata,
    // write_color[0]
    output logic [0:0]                  m_axis_tuser,
    // last_of_run
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [15:0]                 cfg_data
);

    import lps_pkg::*;

    localparam int IDX_W = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_SLOTS - 1);

    // ---------------------------------------------------------------- control
    lps_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    lps_in_t         in_reg;
    lps_req_t        req_reg;
    logic [15:0]     period_reg;
    logic [LED_SLOTS-1:0] valid_reg;
    logic            rd_valid_reg;

    // ---------------------------------------------------------------- table
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_addr;
    lps_entry_t       ram_wr_data;
    logic             ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_raw;
    lps_entry_t       ram_entry;
    lps_entry_t       entry_reg;

    // ---------------------------------------------------------------- divider
    logic             div_start;
    logic [31:0]      div_num;
    logic [15:0]      div_den;
    logic             div_done;
    lps_scale_t       div_res;

    // ---------------------------------------------------------------- output
    logic             out_valid_reg;
    lps_out_t         out_data_reg;
    logic             out_wr_reg;
    logic             out_last_reg;

    logic             in_fire;
    logic             emit_fire;
    logic             req_ok;
    lps_in_t          in_word;
    lps_req_t         in_req;

    // emit computation
    logic [7:0]       res_r, res_g, res_b;
    logic             res_wr;
    lps_entry_t       upd_entry;
    logic             ge_fade, ge_beat, ge_blink;
    logic [5:0]       step_inc;
    logic [7:0]       fade;
    logic [15:0]      prod_r, prod_g, prod_b;
    logic             lit;

    assign in_word = lps_in_t'(s_axis_tdata);
    assign in_req  = lps_req_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign emit_fire     = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    // Drop set and clear for LEDs outside the table, and unknown kinds.
    assign req_ok = (in_req == REQ_RUN) ||
                    (((in_req == REQ_SET) || (in_req == REQ_CLEAR)) &&
                     (in_word.led_select < 8'(LED_SLOTS)));

    // Entries never written read as zero.
    assign ram_entry = rd_valid_reg ? lps_entry_t'(ram_rd_raw) : '0;

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ram_rd_en  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && req_ok)
                begin
                    state_next = ST_READ;
                    idx_next   = (in_req == REQ_RUN) ? '0 : in_word.led_select[IDX_W-1:0];
                end
            end
            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = (req_reg == REQ_RUN) ? ST_LOAD : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Elapsed ticks shifted up by 8, wrapping at 24 bits; a zero period acts as one.
    assign div_num = {16'(24'(in_reg.now - ram_entry.start) >> 8),
                      8'(in_reg.now - ram_entry.start), 8'h00};
    assign div_den = (period_reg == 16'd0) ? 16'd1 : period_reg;

    lps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .res   (div_res)
    );

    // ---------------------------------------------------------------- pattern step
    assign ge_fade  = div_res.sat || (div_res.quo >= TH_FADE);
    assign ge_beat  = div_res.sat || (div_res.quo >= TH_BEAT);
    assign ge_blink = div_res.sat || (div_res.quo >= TH_BLINK);
    assign step_inc = {1'b0, entry_reg.step} + 6'd1;

    // Fade factor stays within 0 to 255 without wrapping whenever it is used.
    assign fade   = (entry_reg.step == BR_FADE_IN) ? div_res.quo[7:0]
                                                   : 8'(8'd255 - div_res.quo[7:0]);
    assign prod_r = 16'(fade) * 16'(entry_reg.red);
    assign prod_g = 16'(fade) * 16'(entry_reg.green);
    assign prod_b = 16'(fade) * 16'(entry_reg.blue);

    always_comb
    begin
        res_r     = 8'd0;
        res_g     = 8'd0;
        res_b     = 8'd0;
        res_wr    = 1'b1;
        lit       = 1'b0;
        upd_entry = entry_reg;
        case (lps_pat_t'(entry_reg.pattern))
            PAT_NONE:
            begin
                res_wr = 1'b0;
            end
            PAT_SOLID:
            begin
                lit = 1'b1;
            end
            PAT_BREATHE:
            begin
                if ((entry_reg.step == BR_FADE_IN) || (entry_reg.step == BR_FADE_OUT))
                begin
                    if (ge_fade)
                    begin
                        // phase transition: advance and leave the LED alone
                        res_wr          = 1'b0;
                        upd_entry.step  = 5'(step_inc);
                        upd_entry.start = in_reg.now;
                    end
                    else
                    begin
                        res_r = prod_r[15:8];
                        res_g = prod_g[15:8];
                        res_b = prod_b[15:8];
                    end
                end
                else if (entry_reg.step == BR_HOLD)
                begin
                    lit = 1'b1;
                    // hold ends once scale reaches 512
                    if (div_res.sat)
                    begin
                        upd_entry.step  = BR_FADE_OUT;
                        upd_entry.start = in_reg.now;
                    end
                end
                else if (entry_reg.step == BR_DARK)
                begin
                    if (ge_fade)
                    begin
                        upd_entry.step  = BR_FADE_IN;
                        upd_entry.start = in_reg.now;
                    end
                end
                else
                begin
                    // stray step: restart the cycle silently
                    res_wr          = 1'b0;
                    upd_entry.step  = BR_FADE_IN;
                    upd_entry.start = in_reg.now;
                end
            end
            PAT_HEARTBEAT:
            begin
                lit = (entry_reg.step == 5'd0) || (entry_reg.step == 5'd2);
                if (ge_beat)
                begin
                    upd_entry.step  = (step_inc > HB_LAST) ? 5'd0 : 5'(step_inc);
                    upd_entry.start = in_reg.now;
                end
            end
            PAT_BLINK:
            begin
                lit = (entry_reg.step == 5'd1);
                if (ge_blink)
                begin
                    upd_entry.step  = (step_inc > BLINK_LAST) ? 5'd0 : 5'(step_inc);
                    upd_entry.start = in_reg.now;
                end
            end
            PAT_SOS:
            begin
                lit = SOS_MASK[entry_reg.step];
                if (ge_beat)
                begin
                    upd_entry.step  = (step_inc > SOS_LAST) ? 5'd0 : 5'(step_inc);
                    upd_entry.start = in_reg.now;
                end
            end
            default:
            begin
                // unknown codes drive black
            end
        endcase
        if (lit)
        begin
            res_r = entry_reg.red;
            res_g = entry_reg.green;
            res_b = entry_reg.blue;
        end
    end

    // ---------------------------------------------------------------- table write
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_data = upd_entry;
        if (state_reg == ST_UPDATE)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_entry;
            if (req_reg == REQ_SET)
            begin
                // keep the step index, replace everything else
                ram_wr_data.pattern = in_reg.pattern_code;
                ram_wr_data.red     = in_reg.red_in;
                ram_wr_data.green   = in_reg.green_in;
                ram_wr_data.blue    = in_reg.blue_in;
                ram_wr_data.start   = in_reg.now;
            end
            else
            begin
                ram_wr_data.pattern = PAT_NONE;
            end
        end
        else if (emit_fire)
        begin
            ram_wr_en = 1'b1;
        end
    end

    assign ram_addr = idx_reg;

    lps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_raw)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            req_reg       <= REQ_RUN;
            period_reg    <= PERIOD_RESET;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (in_fire)
            begin
                req_reg <= in_req;
            end
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (ram_wr_en)
            begin
                valid_reg[ram_addr] <= 1'b1;
            end
            if (ram_rd_en)
            begin
                rd_valid_reg <= valid_reg[ram_addr];
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_word;
        end
        if (state_reg == ST_LOAD)
        begin
            entry_reg <= ram_entry;
        end
        if (emit_fire)
        begin
            out_data_reg.pad        <= '0;
            out_data_reg.led_number <= 6'(idx_reg);
            out_data_reg.red_out    <= res_r;
            out_data_reg.green_out  <= res_g;
            out_data_reg.blue_out   <= res_b;
            out_wr_reg              <= res_wr;
            out_last_reg            <= (idx_reg == IDX_LAST);
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_wr_reg;
    assign m_axis_tlast    = out_last_reg;

    // ---------------------------------------------------------------- checks
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("request taken while a request is in progress");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == ST_EMIT) || (state_reg == ST_UPDATE)))
        else $error("table written outside update or emit");

    a_last_led: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_data_reg.led_number == 6'(LED_SLOTS - 1)))
        else $error("run end marked on wrong LED");

    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && div_done) |=> (state_reg == ST_EMIT))
        else $error("divider result not consumed");

endmodule
